// ===== hdl/ipv4hb_pkg.sv =====
// Shared widths, header field constants and word types for the IPv4 header builder.
`timescale 1ns / 1ps

package ipv4hb_pkg;

    // Field widths
    localparam int unsigned C_LEN_W   = 16;
    localparam int unsigned C_ADDR_W  = 32;
    localparam int unsigned C_PROTO_W = 8;
    localparam int unsigned C_WORD_W  = 32;

    // Header geometry
    localparam int unsigned C_HDR_WORDS = 5;
    localparam int unsigned C_IDX_W     = $clog2(C_HDR_WORDS);
    localparam logic [C_IDX_W-1:0] C_LAST_IDX = C_IDX_W'(C_HDR_WORDS - 1);

    // Fixed header fields
    localparam logic [7:0]         C_VER_IHL     = 8'h45;   // version 4, IHL 5
    localparam logic [7:0]         C_DSCP_ECN    = 8'h00;
    localparam logic [15:0]        C_IDENT       = 16'h0000;
    localparam logic [15:0]        C_FLAGS_DF    = 16'h4000; // don't fragment, offset 0
    localparam logic [7:0]         C_TTL         = 8'hFF;
    localparam logic [C_LEN_W-1:0] C_HDR_BYTES   = 16'd20;
    localparam logic [C_LEN_W-1:0] C_PAYLOAD_MAX = 16'd65515;

    typedef logic [C_LEN_W-1:0]   t_len;
    typedef logic [C_ADDR_W-1:0]  t_addr;
    typedef logic [C_PROTO_W-1:0] t_proto;
    typedef logic [C_WORD_W-1:0]  t_word;

endpackage

// ===== hdl/ipv4hb_if.sv =====
// Valid/ready channel interfaces for send requests and header words.
`timescale 1ns / 1ps

interface ipv4hb_req_if;
    import ipv4hb_pkg::*;

    logic   valid;
    logic   ready;
    t_len   payload_length;
    t_addr  dest_address;
    t_proto protocol_number;

    modport source (output valid, output payload_length, output dest_address,
                    output protocol_number, input ready);
    modport sink   (input valid, input payload_length, input dest_address,
                    input protocol_number, output ready);
endinterface

interface ipv4hb_hdr_if;
    import ipv4hb_pkg::*;

    logic  valid;
    logic  ready;
    t_word header_word;
    logic  last_word;

    modport source (output valid, output header_word, output last_word, input ready);
    modport sink   (input valid, input header_word, input last_word, output ready);
endinterface

// ===== hdl/ipv4_header_builder_core.sv =====
// IPv4 header builder: request register, checksum logic and a five-word output shifter.
//
//  channel   | dir | payload                                         | handshake
//  ----------+-----+-------------------------------------------------+-------------
//  i_req     | in  | payload_length, dest_address, protocol_number   | valid/ready
//  o_hdr     | out | header_word, last_word                          | valid/ready
//  i_cfg_wr  | in  | i_cfg_wr_data (source address)                  | i_cfg_wr_en
//
//  One request yields five words, one per cycle while o_hdr.ready is high; the
//  five-word output register takes the next request only when empty or as its last word leaves.
//  The first word appears once the request has passed the input register and loaded the output shifter.
//  One request waits in the input register while the previous header drains.
//  Synchronous active-low reset empties both stages and clears the source address.
//  A stall on o_hdr holds the current word; the input side stalls once both stages are full.
`timescale 1ns / 1ps

module ipv4_header_builder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ipv4hb_pkg::C_ADDR_W-1:0]     i_cfg_wr_data,
    ipv4hb_req_if.sink                          i_req,
    ipv4hb_hdr_if.source                        o_hdr
);
    import ipv4hb_pkg::*;

    localparam int unsigned C_SUM_W = C_LEN_W + 4;  // nine halfwords need four carry bits

    // Source address register
    t_addr r_src;

    // Request register
    logic   r_req_valid;
    t_len   r_plen;
    t_addr  r_dst;
    t_proto r_proto;

    // Output shifter
    logic               r_out_valid;
    logic [C_IDX_W-1:0] r_word_idx;
    t_word              r_words [C_HDR_WORDS];

    // Handshake terms
    logic req_acc;
    logic out_acc;
    logic out_last;
    logic load;

    // Header assembly
    t_len               plen_sat;
    t_len               hdr_total;
    logic [C_SUM_W-1:0] sum;
    logic [C_LEN_W:0]   fold1;
    t_len               fold2;
    t_len               csum;
    t_word              n_words [C_HDR_WORDS];

    assign out_last = (r_word_idx == C_LAST_IDX);
    assign out_acc  = r_out_valid && o_hdr.ready;
    // Move the request on when the shifter is empty or its last word leaves now
    assign load     = r_req_valid && (!r_out_valid || (out_acc && out_last));
    assign i_req.ready = !r_req_valid || load;
    assign req_acc  = i_req.valid && i_req.ready;

    // Saturate length, sum halfwords, fold carries and invert
    always_comb begin
        plen_sat  = (r_plen > C_PAYLOAD_MAX) ? C_PAYLOAD_MAX : r_plen;
        hdr_total = plen_sat + C_HDR_BYTES;
        sum = C_SUM_W'({C_VER_IHL, C_DSCP_ECN})
            + C_SUM_W'(hdr_total)
            + C_SUM_W'(C_IDENT)
            + C_SUM_W'(C_FLAGS_DF)
            + C_SUM_W'({C_TTL, r_proto})
            + C_SUM_W'(r_src[31:16])
            + C_SUM_W'(r_src[15:0])
            + C_SUM_W'(r_dst[31:16])
            + C_SUM_W'(r_dst[15:0]);
        fold1 = (C_LEN_W + 1)'(sum[C_LEN_W-1:0]) + (C_LEN_W + 1)'(sum[C_SUM_W-1:C_LEN_W]);
        fold2 = fold1[C_LEN_W-1:0] + C_LEN_W'(fold1[C_LEN_W]);
        csum  = ~fold2;

        n_words[0] = {C_VER_IHL, C_DSCP_ECN, hdr_total};
        n_words[1] = {C_IDENT, C_FLAGS_DF};
        n_words[2] = {C_TTL, r_proto, csum};
        n_words[3] = r_src;
        n_words[4] = r_dst;
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src       <= '0;
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_word_idx  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_src <= i_cfg_wr_data;
            end
            if (req_acc) begin
                r_req_valid <= 1'b1;
            end else if (load) begin
                r_req_valid <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
                r_word_idx  <= '0;
            end else if (out_acc) begin
                if (out_last) begin
                    r_out_valid <= 1'b0;
                end else begin
                    r_word_idx <= r_word_idx + 1'b1;
                end
            end
        end
    end

    // Capture request payload
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_plen  <= i_req.payload_length;
            r_dst   <= i_req.dest_address;
            r_proto <= i_req.protocol_number;
        end
    end

    // Load a fresh header or advance to the next word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_words <= n_words;
        end else if (out_acc && !out_last) begin
            for (int k = 0; k < C_HDR_WORDS - 1; k++) begin
                r_words[k] <= r_words[k + 1];
            end
        end
    end

    assign o_hdr.valid       = r_out_valid;
    assign o_hdr.header_word = r_words[0];
    assign o_hdr.last_word   = out_last;

endmodule

// ===== hdl/ipv4hb_checker.sv =====
// Port-level checks for the IPv4 header builder, bound to the top level.
`timescale 1ns / 1ps

module ipv4hb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [ipv4hb_pkg::C_WORD_W-1:0] i_header_word,
    input logic                            i_last_word
);
    import ipv4hb_pkg::*;

    // Hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_header_word) && $stable(i_last_word))
        else $error("header word changed while stalled");

    // Words of one header leave without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_word |=> i_out_valid)
        else $error("gap inside a header");

    // A header that follows a last word opens with version and IHL
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_valid && i_out_ready && i_last_word) && i_out_valid |->
            i_header_word[31:24] == C_VER_IHL && !i_last_word)
        else $error("header does not open with version/IHL");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind ipv4_header_builder_core ipv4hb_checker u_ipv4hb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_hdr.valid),
    .i_out_ready   (o_hdr.ready),
    .i_header_word (o_hdr.header_word),
    .i_last_word   (o_hdr.last_word)
);
